@@ hw/rtl/pwcs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_pkg
// Shared types and constants for the one-wire command sender.
// ----------------------------------------------------------------------------
package pwcs_pkg;

	localparam int HOLD_WIDTH_DEF = 16;
	localparam int HOLD_IN_WIDTH  = 16;
	localparam int DUR_WIDTH      = 8;
	localparam int CFG_IDX_WIDTH  = 2;

	localparam logic [7:0] OPEN_BYTE  = 8'h0A;
	localparam logic [7:0] CLOSE_BYTE = 8'h0B;

	// register indexes on the write port
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START_HIGH = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_START_LOW  = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT      = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG       = 2'd3;

	localparam logic [DUR_WIDTH-1:0] START_HIGH_RST = 8'd1;
	localparam logic [DUR_WIDTH-1:0] START_LOW_RST  = 8'd4;
	localparam logic [DUR_WIDTH-1:0] SHORT_RST      = 8'd1;
	localparam logic [DUR_WIDTH-1:0] LONG_RST       = 8'd21;

	// byte slots within a command sequence
	localparam logic [1:0] SLOT_OPEN  = 2'd0;
	localparam logic [1:0] SLOT_LOW   = 2'd1;
	localparam logic [1:0] SLOT_HIGH  = 2'd2;
	localparam logic [1:0] SLOT_CLOSE = 2'd3;

	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_PLAY = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_START_HIGH = 3'd1,
		PH_START_LOW  = 3'd2,
		PH_BIT_HIGH   = 3'd3,
		PH_BIT_LOW    = 3'd4,
		PH_HOLD       = 3'd5
	} phase_t;

	typedef struct packed {
		logic [DUR_WIDTH-1:0] start_high;
		logic [DUR_WIDTH-1:0] start_low;
		logic [DUR_WIDTH-1:0] short_dur;
		logic [DUR_WIDTH-1:0] long_dur;
	} cfg_t;

	typedef struct packed {
		logic                     func;
		logic [7:0]               song_low;
		logic [7:0]               song_high;
		logic [HOLD_IN_WIDTH-1:0] hold_ticks;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic rejected;
		logic finished;
	} result_t;

	// a zero duration still lasts one tick
	function automatic logic [DUR_WIDTH-1:0] at_least_one(input logic [DUR_WIDTH-1:0] v);
		at_least_one = (v == '0) ? DUR_WIDTH'(1) : v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/pwcs_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwcs_seq
// Sequencer state and per-word step: advances the line waveform by one
// word and produces that word's result.
// ----------------------------------------------------------------------------
module pwcs_seq #(
	parameter int HOLD_WIDTH = pwcs_pkg::HOLD_WIDTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              step,
	input  pwcs_pkg::item_t  item,
	input  pwcs_pkg::cfg_t   cfg,
	output pwcs_pkg::result_t res
);
	import pwcs_pkg::*;

	localparam logic [32:0] HoldMax = (33'd1 << HOLD_WIDTH) - 33'd1;

	phase_t                 phase_q, phase_d;
	logic [1:0]             slot_q, slot_d;
	logic [2:0]             bit_q, bit_d;
	logic [7:0]             shift_q, shift_d;
	logic [DUR_WIDTH-1:0]   seg_q, seg_d;
	logic [HOLD_WIDTH-1:0]  hold_q, hold_d;
	logic [7:0]             saved_low_q, saved_low_d;
	logic [7:0]             saved_high_q, saved_high_d;
	logic [HOLD_WIDTH-1:0]  saved_hold_q, saved_hold_d;
	logic                   line_q, line_d;

	logic [32:0]            hold_ext;
	logic [HOLD_WIDTH-1:0]  hold_sat;
	logic                   seg_done;

	assign hold_ext = {{(33-HOLD_IN_WIDTH){1'b0}}, item.hold_ticks};
	assign hold_sat = (hold_ext > HoldMax) ? HoldMax[HOLD_WIDTH-1:0] : hold_ext[HOLD_WIDTH-1:0];
	assign seg_done = (seg_q <= DUR_WIDTH'(1));

	// next state
	always_comb begin
		logic       begin_byte;
		logic [1:0] begin_slot;
		logic       begin_bit;
		logic       after_song;

		begin_byte   = 1'b0;
		begin_slot   = SLOT_OPEN;
		begin_bit    = 1'b0;
		after_song   = 1'b0;
		phase_d      = phase_q;
		slot_d       = slot_q;
		bit_d        = bit_q;
		shift_d      = shift_q;
		seg_d        = seg_q;
		hold_d       = hold_q;
		saved_low_d  = saved_low_q;
		saved_high_d = saved_high_q;
		saved_hold_d = saved_hold_q;
		line_d       = line_q;

		if (item.func == FUNC_PLAY) begin
			if (phase_q == PH_IDLE) begin
				saved_low_d  = item.song_low;
				saved_high_d = item.song_high;
				saved_hold_d = hold_sat;
				begin_byte   = 1'b1;
				begin_slot   = SLOT_OPEN;
			end
		end else if (phase_q == PH_HOLD) begin
			if (hold_q <= HOLD_WIDTH'(1)) begin
				hold_d     = '0;
				begin_byte = 1'b1;
				begin_slot = SLOT_CLOSE;
			end else begin
				hold_d = hold_q - HOLD_WIDTH'(1);
			end
		end else if (phase_q != PH_IDLE) begin
			if (seg_done) begin
				case (phase_q)
					PH_START_HIGH: begin
						phase_d = PH_START_LOW;
						seg_d   = at_least_one(cfg.start_low);
						line_d  = 1'b0;
					end
					PH_START_LOW: begin
						begin_bit = 1'b1;
					end
					PH_BIT_HIGH: begin
						phase_d = PH_BIT_LOW;
						seg_d   = at_least_one(shift_q[0] ? cfg.long_dur : cfg.short_dur);
						line_d  = 1'b0;
					end
					PH_BIT_LOW: begin
						if (bit_q != 3'd7) begin
							bit_d     = bit_q + 3'd1;
							shift_d   = {1'b0, shift_q[7:1]};
							begin_bit = 1'b1;
						end else begin
							case (slot_q)
								SLOT_OPEN: begin
									begin_byte = 1'b1;
									begin_slot = SLOT_LOW;
								end
								SLOT_LOW: begin
									if (saved_high_q != 8'd0) begin
										begin_byte = 1'b1;
										begin_slot = SLOT_HIGH;
									end else begin
										after_song = 1'b1;
									end
								end
								SLOT_HIGH: begin
									after_song = 1'b1;
								end
								default: begin
									phase_d = PH_IDLE;
									line_d  = 1'b1;
									seg_d   = '0;
									bit_d   = '0;
									slot_d  = SLOT_OPEN;
								end
							endcase
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end else begin
				seg_d = seg_q - DUR_WIDTH'(1);
			end
		end

		if (after_song) begin
			if (saved_hold_q == '0) begin
				begin_byte = 1'b1;
				begin_slot = SLOT_CLOSE;
			end else begin
				hold_d  = saved_hold_q;
				phase_d = PH_HOLD;
				seg_d   = '0;
				line_d  = 1'b1;
			end
		end

		if (begin_byte) begin
			slot_d = begin_slot;
			case (begin_slot)
				SLOT_OPEN: shift_d = OPEN_BYTE;
				SLOT_LOW:  shift_d = saved_low_q;
				SLOT_HIGH: shift_d = saved_high_q;
				default:   shift_d = CLOSE_BYTE;
			endcase
			bit_d   = '0;
			phase_d = PH_START_HIGH;
			seg_d   = at_least_one(cfg.start_high);
			line_d  = 1'b1;
		end

		// bit cell starts from the already shifted byte
		if (begin_bit) begin
			phase_d = PH_BIT_HIGH;
			seg_d   = at_least_one(shift_d[0] ? cfg.short_dur : cfg.long_dur);
			line_d  = 1'b1;
		end
	end

	// result of this word
	always_comb begin
		res.rejected   = (item.func == FUNC_PLAY) && (phase_q != PH_IDLE);
		res.finished   = (item.func == FUNC_TICK) && (phase_q == PH_BIT_LOW) && seg_done &&
		                 (bit_q == 3'd7) && (slot_q == SLOT_CLOSE);
		res.busy_res   = (phase_d != PH_IDLE);
		if (item.func == FUNC_PLAY) begin
			res.line_level = line_q;
		end else if ((phase_q == PH_IDLE) || (phase_q == PH_HOLD)) begin
			res.line_level = 1'b1;
		end else begin
			res.line_level = line_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			slot_q       <= SLOT_OPEN;
			bit_q        <= '0;
			shift_q      <= '0;
			seg_q        <= '0;
			hold_q       <= '0;
			saved_low_q  <= '0;
			saved_high_q <= '0;
			saved_hold_q <= '0;
			line_q       <= 1'b1;
		end else if (step) begin
			phase_q      <= phase_d;
			slot_q       <= slot_d;
			bit_q        <= bit_d;
			shift_q      <= shift_d;
			seg_q        <= seg_d;
			hold_q       <= hold_d;
			saved_low_q  <= saved_low_d;
			saved_high_q <= saved_high_d;
			saved_hold_q <= saved_hold_d;
			line_q       <= line_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/pulse_width_one_wire_command_sender_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_one_wire_command_sender_top
// Pulse-width one-wire command sender: input register, sequencer step,
// result register, and the duration registers.
// ----------------------------------------------------------------------------
// Each input word is a time tick (func 0) or a play command (func 1) and
// yields exactly one result word. A word is held in the input register and
// then stepped through the sequencer into the result register; one word is
// taken every cycle unless the result register is held back, which happens
// only while out_stall is high. The four durations are to be written by
// the user through wr_en/wr_index/wr_data only while the block is idle;
// the block does not enforce this; a zero duration counts as one tick.
// Commands arriving while a sequence runs are dropped and flagged by rejected.
module pulse_width_one_wire_command_sender_top #(
	parameter int HOLD_WIDTH = pwcs_pkg::HOLD_WIDTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire                                   func,
	input  wire  [7:0]                            song_low,
	input  wire  [7:0]                            song_high,
	input  wire  [pwcs_pkg::HOLD_IN_WIDTH-1:0]    hold_ticks,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic                                  line_level,
	output logic                                  busy_res,
	output logic                                  rejected,
	output logic                                  finished,
	input  wire                                   wr_en,
	input  wire  [pwcs_pkg::CFG_IDX_WIDTH-1:0]    wr_index,
	input  wire  [pwcs_pkg::DUR_WIDTH-1:0]        wr_data
);
	import pwcs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;
	logic    out_free;
	logic    step;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_high <= START_HIGH_RST;
			cfg_q.start_low  <= START_LOW_RST;
			cfg_q.short_dur  <= SHORT_RST;
			cfg_q.long_dur   <= LONG_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_HIGH: cfg_q.start_high <= wr_data;
				REG_START_LOW:  cfg_q.start_low  <= wr_data;
				REG_SHORT:      cfg_q.short_dur  <= wr_data;
				REG_LONG:       cfg_q.long_dur   <= wr_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func       <= func;
			item_s1.song_low   <= song_low;
			item_s1.song_high  <= song_high;
			item_s1.hold_ticks <= hold_ticks;
		end
	end

	pwcs_seq #(
		.HOLD_WIDTH(HOLD_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign line_level = res_q.line_level;
	assign busy_res   = res_q.busy_res;
	assign rejected   = res_q.rejected;
	assign finished   = res_q.finished;

endmodule
`default_nettype wire
